### design/lbt_pkg.sv
// Shared types and constants for the LRU byte budget tracker.
// No dependencies; lbt_alu and the tracker core refer to this package by scoped names.
package lbt_pkg;

  localparam int ENTRIES = 64;
  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int DATA_W = 32;
  localparam logic [DATA_W-1:0] RESET_BUDGET = 32'd65536;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_TOUCH  = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OVER_BUDGET = 2'd1,
    ST_TABLE_FULL  = 2'd2,
    ST_BAD_SLOT    = 2'd3
  } status_t;

  typedef enum logic {
    ALU_ADD_CMP = 1'b0,
    ALU_SUB     = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [DATA_W-1:0]   a;
    logic [DATA_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   result;
    logic                over;
  } alu_rsp_t;

endpackage

### design/lbt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/lbt_alu.sv
// Shared 33-bit add-and-compare / subtract unit used by the tracker sequencer.
// Depends on lbt_pkg for the request and response structs.
module lbt_alu (
  input  lbt_pkg::alu_req_t              req,
  input  logic [lbt_pkg::DATA_W-1:0]     limit,
  output lbt_pkg::alu_rsp_t              rsp
);

  logic [lbt_pkg::DATA_W:0] sum;
  logic [lbt_pkg::DATA_W-1:0] diff;

  always_comb begin
    sum  = {1'b0, req.a} + {1'b0, req.b};
    diff = req.a - req.b;
    // The carry is kept so that the budget compare cannot wrap.
    rsp.over   = (sum > {1'b0, limit});
    rsp.result = (req.op == lbt_pkg::ALU_SUB) ? diff : sum[lbt_pkg::DATA_W-1:0];
  end

endmodule

### design/lru_byte_budget_tracker_core.sv
// LRU byte budget tracker: one transaction in, one result out under done.
// Insert and refused actions pass S_CHECK and S_VICTIM, query and remove add S_LINK, touch adds
// S_LINK and S_PUSH; the next start is taken in the cycle the result is shown.
// The steps are set by the link RAM ports: one read, then one write per RAM per cycle.
// The result is shown for one cycle under done; the receiver cannot stall it.
// Synchronous reset empties the order, clears the byte count and restores the budget.
module lru_byte_budget_tracker_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic [5:0]                    entry_slot,
  input  logic [31:0]                   user_id,
  input  logic [31:0]                   value_size,
  input  logic                          cfg_we,
  input  logic [31:0]                   cfg_wdata,
  output logic                          done,
  output logic [5:0]                    assigned_slot,
  output logic [1:0]                    status,
  output logic                          must_evict,
  output logic                          fits_budget,
  output logic                          victim_valid,
  output logic [31:0]                   victim_id,
  output logic [5:0]                    victim_slot,
  output logic [31:0]                   used_total
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_LINK   = 6'b000100,
    S_PUSH   = 6'b001000,
    S_VICTIM = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  localparam int SW = lbt_pkg::SLOT_W;
  localparam int DW = lbt_pkg::DATA_W;

  state_t                  state;
  lbt_pkg::action_t        action_q;
  logic [SW-1:0]           slot_q;
  logic [DW-1:0]           uid_q;
  logic [DW-1:0]           size_q;
  logic [DW-1:0]           max_bytes;
  logic [DW-1:0]           bytes_held;
  logic [SW-1:0]           newest;
  logic [SW-1:0]           oldest;
  logic                    order_empty;
  logic [lbt_pkg::ENTRIES-1:0] in_use;

  logic [SW-1:0]           assigned_q;
  lbt_pkg::status_t        status_q;
  logic                    evict_q;
  logic                    fits_q;

  logic                    accept;
  logic                    free_found;
  logic [SW-1:0]           free_slot;
  logic                    has_older;
  logic                    has_newer;
  logic                    ins_ok;
  lbt_pkg::alu_req_t       alu_req;
  lbt_pkg::alu_rsp_t       alu_rsp;

  logic                    older_we, newer_we, id_we, bytes_we;
  logic [SW-1:0]           older_waddr, newer_waddr;
  logic [SW-1:0]           older_wdata, newer_wdata;
  logic [SW-1:0]           older_rd, newer_rd;
  logic [DW-1:0]           id_rd, bytes_rd;

  assign busy   = !(state == S_IDLE || state == S_DONE);
  assign accept = start && !busy;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = lbt_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  // A slot in the order has an older neighbour unless it is the oldest, and likewise newer.
  assign has_older = (slot_q != oldest);
  assign has_newer = (slot_q != newest);

  always_comb begin
    alu_req.op = lbt_pkg::ALU_ADD_CMP;
    alu_req.a  = bytes_held;
    alu_req.b  = size_q;
    if (state == S_LINK) begin
      if (action_q == lbt_pkg::ACT_QUERY) begin
        alu_req.a = '0;
      end else begin
        alu_req.op = lbt_pkg::ALU_SUB;
        alu_req.b  = bytes_rd;
      end
    end
  end

  lbt_alu u_alu (
    .req   (alu_req),
    .limit (max_bytes),
    .rsp   (alu_rsp)
  );

  assign ins_ok = (action_q == lbt_pkg::ACT_INSERT) && !alu_rsp.over && free_found;

  always_comb begin
    older_we    = 1'b0;
    newer_we    = 1'b0;
    id_we       = 1'b0;
    bytes_we    = 1'b0;
    older_waddr = slot_q;
    older_wdata = newest;
    newer_waddr = newest;
    newer_wdata = slot_q;
    unique case (state)
      S_CHECK: begin
        if (ins_ok) begin
          id_we       = 1'b1;
          bytes_we    = 1'b1;
          older_we    = !order_empty;
          older_waddr = free_slot;
          newer_we    = !order_empty;
          newer_wdata = free_slot;
        end
      end
      S_LINK: begin
        if (action_q == lbt_pkg::ACT_TOUCH || action_q == lbt_pkg::ACT_REMOVE) begin
          older_we    = has_newer;
          older_waddr = newer_rd;
          older_wdata = older_rd;
          newer_we    = has_older;
          newer_waddr = older_rd;
          newer_wdata = newer_rd;
        end
      end
      S_PUSH: begin
        older_we = !order_empty;
        newer_we = !order_empty;
      end
      default: begin
      end
    endcase
  end

  lbt_ram #(.WIDTH(SW), .DEPTH(lbt_pkg::ENTRIES)) u_older_ram (
    .clk(clk), .we(older_we), .waddr(older_waddr), .wdata(older_wdata),
    .raddr(slot_q), .rdata(older_rd)
  );

  lbt_ram #(.WIDTH(SW), .DEPTH(lbt_pkg::ENTRIES)) u_newer_ram (
    .clk(clk), .we(newer_we), .waddr(newer_waddr), .wdata(newer_wdata),
    .raddr(slot_q), .rdata(newer_rd)
  );

  lbt_ram #(.WIDTH(DW), .DEPTH(lbt_pkg::ENTRIES)) u_id_ram (
    .clk(clk), .we(id_we), .waddr(free_slot), .wdata(uid_q),
    .raddr(oldest), .rdata(id_rd)
  );

  lbt_ram #(.WIDTH(DW), .DEPTH(lbt_pkg::ENTRIES)) u_bytes_ram (
    .clk(clk), .we(bytes_we), .waddr(free_slot), .wdata(size_q),
    .raddr(slot_q), .rdata(bytes_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      max_bytes   <= lbt_pkg::RESET_BUDGET;
      bytes_held  <= '0;
      newest      <= '0;
      oldest      <= '0;
      order_empty <= 1'b1;
      in_use      <= '0;
    end else begin
      if (cfg_we) begin
        max_bytes <= cfg_wdata;
      end
      unique case (state) inside
        S_IDLE, S_DONE: begin
          if (accept) begin
            action_q   <= lbt_pkg::action_t'(action);
            slot_q     <= entry_slot;
            uid_q      <= user_id;
            size_q     <= value_size;
            assigned_q <= '0;
            status_q   <= lbt_pkg::ST_OK;
            evict_q    <= 1'b0;
            fits_q     <= 1'b0;
            state      <= S_CHECK;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CHECK: begin
          case (action_q) inside
            lbt_pkg::ACT_INSERT: begin
              state <= S_VICTIM;
              if (alu_rsp.over) begin
                status_q <= lbt_pkg::ST_OVER_BUDGET;
              end else if (!free_found) begin
                status_q <= lbt_pkg::ST_TABLE_FULL;
              end else begin
                in_use[free_slot] <= 1'b1;
                assigned_q        <= free_slot;
                bytes_held        <= alu_rsp.result;
                newest            <= free_slot;
                order_empty       <= 1'b0;
                if (order_empty) begin
                  oldest <= free_slot;
                end
              end
            end
            lbt_pkg::ACT_TOUCH, lbt_pkg::ACT_REMOVE: begin
              if (!in_use[slot_q]) begin
                status_q <= lbt_pkg::ST_BAD_SLOT;
                state    <= S_VICTIM;
              end else begin
                state <= S_LINK;
              end
            end
            default: begin
              evict_q <= alu_rsp.over;
              state   <= S_LINK;
            end
          endcase
        end
        S_LINK: begin
          if (action_q == lbt_pkg::ACT_QUERY) begin
            fits_q <= !alu_rsp.over;
            state  <= S_VICTIM;
          end else begin
            if (!has_newer && has_older) begin
              newest <= older_rd;
            end
            if (!has_older && has_newer) begin
              oldest <= newer_rd;
            end
            if (!has_older && !has_newer) begin
              order_empty <= 1'b1;
              newest      <= '0;
              oldest      <= '0;
            end
            if (action_q == lbt_pkg::ACT_TOUCH) begin
              state <= S_PUSH;
            end else begin
              in_use[slot_q] <= 1'b0;
              bytes_held     <= alu_rsp.result;
              state          <= S_VICTIM;
            end
          end
        end
        S_PUSH: begin
          if (order_empty) begin
            oldest <= slot_q;
          end
          newest      <= slot_q;
          order_empty <= 1'b0;
          state       <= S_VICTIM;
        end
        S_VICTIM: begin
          state <= S_DONE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign done          = (state == S_DONE);
  assign assigned_slot = assigned_q;
  assign status        = status_q;
  assign must_evict    = evict_q;
  assign fits_budget   = fits_q;
  assign victim_valid  = !order_empty;
  assign victim_id     = order_empty ? '0 : id_rd;
  assign victim_slot   = order_empty ? '0 : oldest;
  assign used_total    = bytes_held;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_after_victim: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_VICTIM))
    else $error("result shown without a victim read");

  // A touch of the only item leaves the order empty for one cycle while the slot stays held.
  a_empty_no_items: assert property (@(posedge clk) disable iff (rst)
    (order_empty && state != S_PUSH) |-> (in_use == '0 && bytes_held == '0))
    else $error("empty order still holds slots or bytes");

  a_bad_slot_action: assert property (@(posedge clk) disable iff (rst)
    (done && status_q == lbt_pkg::ST_BAD_SLOT) |->
      (action_q == lbt_pkg::ACT_TOUCH || action_q == lbt_pkg::ACT_REMOVE))
    else $error("slot error reported for an action without a slot");

  a_oldest_in_use: assert property (@(posedge clk) disable iff (rst)
    (done && !order_empty) |-> (in_use[oldest] && in_use[newest]))
    else $error("order ends point at a free slot");

endmodule

### tb/sv/lru_byte_budget_tracker_checker.sv
// Checker for the LRU byte budget tracker: keeps its own copy of the recency order,
// predicts each result when a transaction is accepted and compares it with the DUT.
// Depends on lbt_pkg for the action and status codes.
`timescale 1ns / 100ps

module lru_byte_budget_tracker_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action,
  input  logic [5:0]  entry_slot,
  input  logic [31:0] user_id,
  input  logic [31:0] value_size,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        done,
  input  logic [5:0]  assigned_slot,
  input  logic [1:0]  status,
  input  logic        must_evict,
  input  logic        fits_budget,
  input  logic        victim_valid,
  input  logic [31:0] victim_id,
  input  logic [5:0]  victim_slot,
  input  logic [31:0] used_total,
  output int          errors,
  output int          outstanding
);
  import lbt_pkg::*;

  localparam int SLOT_LIMIT = (ENTRIES < 64) ? ENTRIES : 64;

  typedef struct {
    logic [5:0]  slot;
    status_t     st;
    logic        evict;
    logic        fits;
    logic        vvalid;
    logic [31:0] vid;
    logic [5:0]  vslot;
    logic [31:0] used;
  } lbt_result_t;

  lbt_result_t expected_q[$];

  logic [31:0] budget;
  logic [5:0]  toward_old [ENTRIES];
  logic [5:0]  toward_new [ENTRIES];
  logic        linked_old [ENTRIES];
  logic        linked_new [ENTRIES];
  logic        occupied   [ENTRIES];
  logic [31:0] slot_uid   [ENTRIES];
  logic [31:0] slot_bytes [ENTRIES];
  logic [5:0]  newest;
  logic [5:0]  oldest;
  logic        none_held;
  logic [31:0] held;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic void make_newest(logic [5:0] s);
    linked_new[s] = 1'b0;
    if (!none_held) begin
      toward_new[newest] = s;
      linked_new[newest] = 1'b1;
      toward_old[s] = newest;
      linked_old[s] = 1'b1;
    end else begin
      linked_old[s] = 1'b0;
      oldest = s;
    end
    newest = s;
    none_held = 1'b0;
  endfunction

  function automatic lbt_result_t predict_outcome(action_t act, logic [5:0] slot,
                                                  logic [31:0] uid, logic [31:0] size);
    lbt_result_t r;
    logic [32:0] sum;
    int          free_slot;
    sum = {1'b0, held} + {1'b0, size};
    r.slot = '0;
    r.st = ST_OK;
    r.evict = 1'b0;
    r.fits = 1'b0;
    case (act)
      ACT_INSERT: begin
        // The budget check takes precedence over the table-full check.
        if (sum > {1'b0, budget}) begin
          r.st = ST_OVER_BUDGET;
        end else begin
          free_slot = -1;
          for (int i = SLOT_LIMIT - 1; i >= 0; i--) begin
            if (!occupied[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            r.st = ST_TABLE_FULL;
          end else begin
            occupied[free_slot] = 1'b1;
            slot_uid[free_slot] = uid;
            slot_bytes[free_slot] = size;
            make_newest(6'(free_slot));
            held = sum[31:0];
            r.slot = 6'(free_slot);
          end
        end
      end
      ACT_TOUCH, ACT_REMOVE: begin
        if (int'(slot) >= SLOT_LIMIT || !occupied[slot]) begin
          r.st = ST_BAD_SLOT;
        end else begin
          // Unlink the slot, patching its neighbours or the ends of the order.
          if (linked_new[slot]) begin
            toward_old[toward_new[slot]] = toward_old[slot];
            linked_old[toward_new[slot]] = linked_old[slot];
          end else if (linked_old[slot]) begin
            newest = toward_old[slot];
          end
          if (linked_old[slot]) begin
            toward_new[toward_old[slot]] = toward_new[slot];
            linked_new[toward_old[slot]] = linked_new[slot];
          end else if (linked_new[slot]) begin
            oldest = toward_new[slot];
          end
          if (!linked_old[slot] && !linked_new[slot]) begin
            none_held = 1'b1;
            newest = '0;
            oldest = '0;
          end
          linked_old[slot] = 1'b0;
          linked_new[slot] = 1'b0;
          if (act == ACT_TOUCH) begin
            make_newest(slot);
          end else begin
            occupied[slot] = 1'b0;
            held = held - slot_bytes[slot];
          end
        end
      end
      default: begin
        r.evict = sum > {1'b0, budget};
        r.fits = size <= budget;
      end
    endcase
    r.vvalid = !none_held;
    r.vid = none_held ? 32'd0 : slot_uid[oldest];
    r.vslot = none_held ? 6'd0 : oldest;
    r.used = held;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    lbt_result_t want;
    if (rst) begin
      budget = RESET_BUDGET;
      for (int i = 0; i < ENTRIES; i++) begin
        toward_old[i] = '0;
        toward_new[i] = '0;
        linked_old[i] = 1'b0;
        linked_new[i] = 1'b0;
        occupied[i] = 1'b0;
        slot_uid[i] = '0;
        slot_bytes[i] = '0;
      end
      newest = '0;
      oldest = '0;
      none_held = 1'b1;
      held = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) budget = cfg_wdata;
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result seen with no transaction outstanding");
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("assigned_slot", 32'(want.slot), 32'(assigned_slot));
          check_field("status", 32'(want.st), 32'(status));
          check_field("must_evict", 32'(want.evict), 32'(must_evict));
          check_field("fits_budget", 32'(want.fits), 32'(fits_budget));
          check_field("victim_valid", 32'(want.vvalid), 32'(victim_valid));
          check_field("victim_id", want.vid, victim_id);
          check_field("victim_slot", 32'(want.vslot), 32'(victim_slot));
          check_field("used_total", want.used, used_total);
        end
      end
      if (start && !busy) begin
        expected_q.push_back(predict_outcome(action_t'(action), entry_slot, user_id,
                                             value_size));
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

### tb/sv/lru_byte_budget_tracker_core_test.sv
// Top of the LRU byte budget tracker testbench: clock, reset, stimulus and verdict.
// Depends on lbt_pkg, lru_byte_budget_tracker_core and lru_byte_budget_tracker_checker.
`timescale 1ns / 100ps

module lru_byte_budget_tracker_core_test;
  import lbt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 232;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  action = ACT_QUERY;
  logic [5:0]  entry_slot = '0;
  logic [31:0] user_id = '0;
  logic [31:0] value_size = '0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  logic        busy;
  logic        done;
  logic [5:0]  assigned_slot;
  logic [1:0]  status;
  logic        must_evict;
  logic        fits_budget;
  logic        victim_valid;
  logic [31:0] victim_id;
  logic [5:0]  victim_slot;
  logic [31:0] used_total;

  int errors;
  int outstanding;
  int cycle_count = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  lru_byte_budget_tracker_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .entry_slot(entry_slot), .user_id(user_id), .value_size(value_size),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .assigned_slot(assigned_slot), .status(status),
    .must_evict(must_evict), .fits_budget(fits_budget), .victim_valid(victim_valid),
    .victim_id(victim_id), .victim_slot(victim_slot), .used_total(used_total)
  );

  lru_byte_budget_tracker_checker lru_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .entry_slot(entry_slot), .user_id(user_id), .value_size(value_size),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .assigned_slot(assigned_slot), .status(status),
    .must_evict(must_evict), .fits_budget(fits_budget), .victim_valid(victim_valid),
    .victim_id(victim_id), .victim_slot(victim_slot), .used_total(used_total),
    .errors(errors), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sends one transaction; between bursts of random length the request line usually idles.
  task automatic issue(action_t act, logic [5:0] slot, logic [31:0] uid, logic [31:0] size);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    action <= act;
    entry_slot <= slot;
    user_id <= uid;
    value_size <= size;
    do @(posedge clk); while (busy);
  endtask

  // The budget is only rewritten once every outstanding result has come back.
  task automatic set_budget(logic [31:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] budget_plan [6];
    logic [31:0] limit;
    logic [31:0] size;
    logic [5:0]  slot;
    action_t     act;
    int          mode;
    int          pick;

    budget_plan = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd3000, $urandom(), 32'd1000000};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, under the budget left by reset.
    issue(ACT_QUERY, 6'd0, 32'd0, 32'd0);
    issue(ACT_TOUCH, 6'd0, 32'd0, 32'd0);
    issue(ACT_REMOVE, 6'd63, 32'd0, 32'd0);
    issue(ACT_INSERT, 6'd0, 32'hFFFF_FFFF, 32'd0);
    issue(ACT_INSERT, 6'd0, 32'd0, 32'd65536);
    issue(ACT_INSERT, 6'd0, 32'h1234_5678, 32'd1);
    issue(ACT_QUERY, 6'd0, 32'd0, 32'd0);
    issue(ACT_QUERY, 6'd0, 32'd0, 32'd1);
    issue(ACT_QUERY, 6'd0, 32'd0, 32'hFFFF_FFFF);
    issue(ACT_TOUCH, 6'd0, 32'd0, 32'd0);
    issue(ACT_TOUCH, 6'd0, 32'd0, 32'd0);
    issue(ACT_REMOVE, 6'd1, 32'd0, 32'd0);
    issue(ACT_REMOVE, 6'd1, 32'd0, 32'd0);
    issue(ACT_INSERT, 6'd0, 32'hA5A5_A5A5, 32'd100);
    issue(ACT_INSERT, 6'd0, 32'h5A5A_5A5A, 32'd200);
    issue(ACT_TOUCH, 6'd1, 32'd0, 32'd0);
    issue(ACT_REMOVE, 6'd1, 32'd0, 32'd0);
    // Budget pulled below the bytes already held: items stay, inserts are refused until bytes are removed.
    set_budget(32'd50);
    issue(ACT_INSERT, 6'd0, 32'hDEAD_0001, 32'd0);
    issue(ACT_REMOVE, 6'd2, 32'd0, 32'd0);
    issue(ACT_INSERT, 6'd0, 32'hDEAD_0002, 32'd50);
    issue(ACT_QUERY, 6'd0, 32'd0, 32'hFFFF_FFFF);
    issue(ACT_REMOVE, 6'd0, 32'd0, 32'd0);
    issue(ACT_REMOVE, 6'd1, 32'd0, 32'd0);

    // Random part: each budget phase mixes fill, churn and drain stretches picked at random.
    mode = 0;
    for (int phase = 0; phase < 6; phase++) begin
      limit = budget_plan[phase];
      set_budget(limit);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) mode = $urandom_range(0, 2);
        pick = $urandom_range(0, 99);
        case (mode)
          0:       act = (pick < 60) ? ACT_INSERT : (pick < 75) ? ACT_TOUCH :
                         (pick < 85) ? ACT_REMOVE : ACT_QUERY;
          1:       act = (pick < 30) ? ACT_INSERT : (pick < 60) ? ACT_TOUCH :
                         (pick < 85) ? ACT_REMOVE : ACT_QUERY;
          default: act = (pick < 10) ? ACT_INSERT : (pick < 30) ? ACT_TOUCH :
                         (pick < 85) ? ACT_REMOVE : ACT_QUERY;
        endcase
        // Free slots are handed out lowest first, so low slot numbers hit live items.
        case ($urandom_range(0, 3))
          0:       slot = 6'($urandom_range(0, 7));
          1:       slot = 6'($urandom_range(0, 15));
          2:       slot = 6'($urandom_range(0, 31));
          default: slot = 6'($urandom_range(0, 63));
        endcase
        case ($urandom_range(0, 15))
          0, 1:    size = 32'd0;
          2:       size = $urandom();
          3:       size = 32'hFFFF_FFFF;
          default: size = $urandom_range(0, limit / 40 + 1);
        endcase
        issue(act, slot, $urandom(), size);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
